/* rtl/sflm_pkg.sv */
// Shared types and constants for the slot free list manager.
`timescale 1ns / 1ps

package sflm_pkg;

   localparam int SLOTS_DEF  = 1024;
   localparam int SLOT_W     = 10;
   localparam int CNT_W      = 10;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PIN     = 2'd2;

   // Flag memory word: on-list bit and occupied bit.
   localparam int FLG_W   = 2;
   localparam int FLG_ONL = 0;
   localparam int FLG_OCC = 1;

   typedef struct packed {
      logic [CNT_W-1:0]  free_count;
      logic              changed;
      logic              evicted;
      logic              granted;
      logic [SLOT_W-1:0] granted_slot;
   } rsp_type;

endpackage

/* rtl/slot_free_list_manager_top.sv */
// Top level of the slot free list manager.
//
//   Channel  Direction  Beat contents
//   req_     in         tuser: command; tdata: slot, still_referenced
//   rsp_     out        tdata: granted_slot, granted, evicted, changed, free_count
//
// A command is taken in the idle state and runs in the execute state before the next is taken;
// a release that changes the list also passes a second write state: each link memory has
// one write port, and release writes two back links. The result beat is registered from
// the execute state into the output register (or the skid entry). After reset a clearing
// pass writes all SLOTS entries, one per cycle, with req_tready low until the pass ends.
// A finished result waits in the output register while the next command is taken;
// a second waiting result stops intake until the consumer drains.
`timescale 1ns / 1ps

module slot_free_list_manager_top #(
   parameter int SLOTS = sflm_pkg::SLOTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sflm_pkg::CMD_W-1:0]         req_tuser,  // [1:0] command
   input  logic [sflm_pkg::REQ_DATA_W-1:0]    req_tdata,  // [9:0] slot, [10] still_referenced
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] granted_slot, [10] granted, [11] evicted, [12] changed, [22:13] free_count
   output logic [sflm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import sflm_pkg::*;

   localparam int AW = $clog2(SLOTS);

   logic             res_ready;
   logic             res_valid;
   rsp_type          res_data;
   rsp_type          rsp_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    nxt_rd_data, prv_rd_data;
   logic [FLG_W-1:0] flg_rd_data;
   logic             nxt_we, prv_we, flg_we;
   logic [AW-1:0]    nxt_wa, prv_wa, flg_wa;
   logic [AW-1:0]    nxt_wd, prv_wd;
   logic [FLG_W-1:0] flg_wd;

   sflm_ctrl #(.SLOTS(SLOTS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_cmd     (req_tuser),
      .req_slot    (req_tdata[SLOT_W-1:0]),
      .req_ref     (req_tdata[SLOT_W]),
      .res_ready   (res_ready),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .nxt_rd_data (nxt_rd_data),
      .prv_rd_data (prv_rd_data),
      .flg_rd_data (flg_rd_data),
      .nxt_we      (nxt_we),
      .nxt_wa      (nxt_wa),
      .nxt_wd      (nxt_wd),
      .prv_we      (prv_we),
      .prv_wa      (prv_wa),
      .prv_wd      (prv_wd),
      .flg_we      (flg_we),
      .flg_wa      (flg_wa),
      .flg_wd      (flg_wd)
   );

   sflm_ram #(.DEPTH(SLOTS), .WIDTH(AW)) u_next_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (nxt_rd_data)
   );

   sflm_ram #(.DEPTH(SLOTS), .WIDTH(AW)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prv_rd_data)
   );

   sflm_ram #(.DEPTH(SLOTS), .WIDTH(FLG_W)) u_flag_ram (
      .clock   (clock),
      .wr_en   (flg_we),
      .wr_addr (flg_wa),
      .wr_data (flg_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (flg_rd_data)
   );

   sflm_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_data   (res_data),
      .res_ready  (res_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {1'b0, rsp_data.free_count, rsp_data.changed, rsp_data.evicted,
                       rsp_data.granted, rsp_data.granted_slot};

endmodule

/* rtl/sflm_ram.sv */
// Synchronous single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module sflm_ram #(
   parameter int DEPTH = sflm_pkg::SLOTS_DEF,
   parameter int WIDTH = sflm_pkg::SLOT_W,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import sflm_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sflm_ctrl.sv */
// Command sequencer: clearing pass, link reads, list updates, head and count.
`timescale 1ns / 1ps

module sflm_ctrl #(
   parameter int SLOTS = sflm_pkg::SLOTS_DEF,
   localparam int AW   = $clog2(SLOTS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sflm_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sflm_pkg::SLOT_W-1:0]  req_slot,
   input  logic                         req_ref,
   input  logic                         res_ready,
   output logic                         res_valid,
   output sflm_pkg::rsp_type            res_data,
   output logic                         rd_en,
   output logic [AW-1:0]                rd_addr,
   input  logic [AW-1:0]                nxt_rd_data,
   input  logic [AW-1:0]                prv_rd_data,
   input  logic [sflm_pkg::FLG_W-1:0]   flg_rd_data,
   output logic                         nxt_we,
   output logic [AW-1:0]                nxt_wa,
   output logic [AW-1:0]                nxt_wd,
   output logic                         prv_we,
   output logic [AW-1:0]                prv_wa,
   output logic [AW-1:0]                prv_wd,
   output logic                         flg_we,
   output logic [AW-1:0]                flg_wa,
   output logic [sflm_pkg::FLG_W-1:0]   flg_wd
);
   import sflm_pkg::*;

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_WR2  = 2'd3;

   localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

   logic [1:0]       state_ff, state_in;
   logic [AW-1:0]    init_cnt_ff, init_cnt_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [AW-1:0]    free_ff, free_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic             slot_ok_ff, slot_ok_in;
   logic             ref_ff, ref_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE) && res_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      cmd_in      = cmd_ff;
      slot_in     = slot_ff;
      slot_ok_in  = slot_ok_ff;
      ref_in      = ref_ff;
      rd_en       = accept;
      rd_addr     = (req_cmd == CMD_ALLOC) ? head_ff : AW'(req_slot);
      nxt_we      = 1'b0;
      nxt_wa      = slot_ff;
      nxt_wd      = '0;
      prv_we      = 1'b0;
      prv_wa      = slot_ff;
      prv_wd      = '0;
      flg_we      = 1'b0;
      flg_wa      = slot_ff;
      flg_wd      = '0;
      res_valid   = 1'b0;
      res_data    = '0;

      case (state_ff)
         ST_INIT: begin
            // Write the reset contents of every slot, one slot a cycle.
            nxt_we = 1'b1;
            nxt_wa = init_cnt_ff;
            nxt_wd = (init_cnt_ff == '0 || init_cnt_ff == LAST_SLOT) ?
                     '0 : init_cnt_ff + AW'(1);
            prv_we = 1'b1;
            prv_wa = init_cnt_ff;
            prv_wd = (init_cnt_ff == '0) ? '0 : init_cnt_ff - AW'(1);
            flg_we = 1'b1;
            flg_wa = init_cnt_ff;
            flg_wd[FLG_ONL] = (init_cnt_ff != '0);
            flg_wd[FLG_OCC] = 1'b0;
            if (init_cnt_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               init_cnt_in = init_cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               slot_in    = AW'(req_slot);
               slot_ok_in = (req_slot != '0) && (32'(req_slot) < 32'(SLOTS));
               ref_in     = req_ref;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in  = ST_IDLE;
            res_valid = 1'b1;
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (head_ff != '0 && free_ff != '0) begin
                     head_in = nxt_rd_data;
                     prv_we  = (nxt_rd_data != '0);
                     prv_wa  = nxt_rd_data;
                     prv_wd  = '0;
                     flg_we  = 1'b1;
                     flg_wa  = head_ff;
                     flg_wd[FLG_ONL] = 1'b0;
                     flg_wd[FLG_OCC] = 1'b1;
                     free_in = free_ff - AW'(1);
                     res_data.granted_slot = SLOT_W'(head_ff);
                     res_data.granted      = 1'b1;
                     res_data.evicted      = flg_rd_data[FLG_OCC];
                  end
               end
               CMD_RELEASE: begin
                  if (!ref_ff && slot_ok_ff && !flg_rd_data[FLG_ONL]) begin
                     nxt_we  = 1'b1;
                     nxt_wa  = slot_ff;
                     nxt_wd  = head_ff;
                     prv_we  = (head_ff != '0);
                     prv_wa  = head_ff;
                     prv_wd  = slot_ff;
                     flg_we  = 1'b1;
                     flg_wa  = slot_ff;
                     flg_wd[FLG_ONL] = 1'b1;
                     flg_wd[FLG_OCC] = flg_rd_data[FLG_OCC];
                     head_in = slot_ff;
                     free_in = free_ff + AW'(1);
                     res_data.changed = 1'b1;
                     // The new head's back link is cleared in the next cycle.
                     state_in = ST_WR2;
                  end
               end
               CMD_PIN: begin
                  if (slot_ok_ff && flg_rd_data[FLG_ONL]) begin
                     prv_we = (nxt_rd_data != '0);
                     prv_wa = nxt_rd_data;
                     prv_wd = prv_rd_data;
                     nxt_we = (prv_rd_data != '0);
                     nxt_wa = prv_rd_data;
                     nxt_wd = nxt_rd_data;
                     if (prv_rd_data == '0) begin
                        head_in = nxt_rd_data;
                     end
                     flg_we = 1'b1;
                     flg_wa = slot_ff;
                     flg_wd[FLG_ONL] = 1'b0;
                     flg_wd[FLG_OCC] = flg_rd_data[FLG_OCC];
                     if (free_ff != '0) begin
                        free_in = free_ff - AW'(1);
                     end
                     res_data.changed = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            res_data.free_count = CNT_W'(free_in);
         end
         ST_WR2: begin
            prv_we   = 1'b1;
            prv_wa   = slot_ff;
            prv_wd   = '0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         init_cnt_ff <= '0;
         head_ff     <= AW'(1);
         free_ff     <= LAST_SLOT;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         head_ff     <= head_in;
         free_ff     <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      slot_ff    <= slot_in;
      slot_ok_ff <= slot_ok_in;
      ref_ff     <= ref_in;
   end

endmodule

/* rtl/sflm_rsp_buf.sv */
// Result output register with one skid entry behind it.
`timescale 1ns / 1ps

module sflm_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   input  sflm_pkg::rsp_type res_data,
   output logic              res_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output sflm_pkg::rsp_type rsp_data
);
   import sflm_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   logic    pend_valid_ff, pend_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type pend_data_ff, pend_data_in;
   logic    rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in  = pend_data_ff;
      if (rsp_free) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = pend_data_ff;
            pend_valid_in = res_valid;
            pend_data_in  = res_data;
         end else begin
            rsp_valid_in = res_valid;
            rsp_data_in  = res_data;
         end
      end else if (res_valid) begin
         pend_valid_in = 1'b1;
         pend_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      pend_data_ff <= pend_data_in;
   end

   assign res_ready  = !pend_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* rtl/sflm_checker.sv */
// Port-level checks for the slot free list manager, bound to the top level.
`timescale 1ns / 1ps

module sflm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sflm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import sflm_pkg::*;

   // The clearing pass keeps intake and output closed right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("beat channel open in the cycle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed or vanished");

   // A grant comes only from allocate, so it names a real slot and changes nothing.
   a_grant_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[9:0] != '0 && !rsp_tdata[12])
      else $error("granted beat with sentinel slot or changed flag");

   a_no_grant_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[10] |-> rsp_tdata[9:0] == '0 && !rsp_tdata[11])
      else $error("slot or eviction reported without a grant");

endmodule

bind slot_free_list_manager_top sflm_checker u_sflm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
